// ===== design/spd_pkg.sv =====
// shared types and constants for the serial packet deframer
// no dependencies; used by spd_parser and serial_packet_deframer
package spd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned TYPE_W  = 6;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h4B;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h53;
    localparam logic [BYTE_W-1:0] TRL_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] TRL_LF     = 8'h0A;
    localparam logic [LEN_W-1:0]  MIN_LENGTH = 10'd8;
    localparam logic [LEN_W-1:0]  BODY_START = 10'd6;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT_K = 3'd0,
        PH_HUNT_S = 3'd1,
        PH_LEN    = 3'd2,
        PH_TYPE   = 3'd3,
        PH_P1     = 3'd4,
        PH_P2     = 3'd5,
        PH_BODY   = 3'd6
    } phase_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic [TYPE_W-1:0] packet_kind;
        logic [BYTE_W-1:0] first_param;
        logic [BYTE_W-1:0] second_param;
        logic [LEN_W-1:0]  total_length;
    } result_t;

endpackage

// ===== design/serial_packet_deframer.sv =====
// serial packet deframer top level: input register, parser, result register
// depends on spd_pkg and spd_parser
//
//  channel   direction  ports
//  s_        in         s_valid, s_ready, s_rx_byte
//  m_        out        m_valid, m_ready, m_kind .. m_total_length
//
// one byte per cycle unless a held result stalls it; each byte is registered in the input register
// before the parser sees it, and its result, if any, goes through the result register to m_
// a held result stalls the parser; the input register still takes one byte meanwhile
// aresetn is synchronous, active low, and returns the parser to header hunt
module serial_packet_deframer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_rx_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_kind,
    output logic [7:0]              m_payload_byte,
    output logic [9:0]              m_payload_index,
    output logic [5:0]              m_packet_kind,
    output logic [7:0]              m_first_param,
    output logic [7:0]              m_second_param,
    output logic [9:0]              m_total_length
);
    import spd_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    result_t           parse_res;
    result_t           out_reg;
    logic              out_valid_reg, out_valid_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = advance ? parse_res.valid : (out_valid_reg && !m_ready);

    spd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (parse_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && parse_res.valid) begin
            out_reg <= parse_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_index = out_reg.payload_index;
    assign m_packet_kind   = out_reg.packet_kind;
    assign m_first_param   = out_reg.first_param;
    assign m_second_param  = out_reg.second_param;
    assign m_total_length  = out_reg.total_length;

endmodule

// ===== design/spd_parser.sv =====
// packet framing state machine: header hunt, length/type/params, body and trailer check
// depends on spd_pkg
module spd_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [spd_pkg::BYTE_W-1:0] rx_byte,
    output spd_pkg::result_t       result
);
    import spd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [TYPE_W-1:0]  type_reg, type_next;
    logic [BYTE_W-1:0]  param_one_reg, param_one_next;
    logic [BYTE_W-1:0]  param_two_reg, param_two_next;
    logic               cr_seen_reg, cr_seen_next;

    logic [LEN_W-1:0]   len_full;
    logic [LEN_W:0]     pos_plus1;
    logic [LEN_W:0]     pos_plus2;
    logic               is_last;
    logic               is_cr_slot;

    assign len_full   = {rx_byte[7:6], length_reg[7:0]};
    assign pos_plus1  = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign pos_plus2  = {1'b0, pos_reg} + {{(LEN_W-1){1'b0}}, 2'd2};
    assign is_last    = pos_plus1 >= {1'b0, length_reg};
    assign is_cr_slot = pos_plus2 == {1'b0, length_reg};

    // next phase
    always_comb begin
        case (phase_reg)
            PH_HUNT_S: begin
                if (rx_byte == HDR_SECOND) begin
                    phase_next = PH_LEN;
                end else if (rx_byte != HDR_FIRST) begin
                    phase_next = PH_HUNT_K;
                end else begin
                    phase_next = PH_HUNT_S;
                end
            end
            PH_LEN:  phase_next = PH_TYPE;
            PH_TYPE: phase_next = (len_full < MIN_LENGTH) ? PH_HUNT_K : PH_P1;
            PH_P1:   phase_next = PH_P2;
            PH_P2:   phase_next = PH_BODY;
            PH_BODY: phase_next = is_last ? PH_HUNT_K : PH_BODY;
            default: phase_next = (rx_byte == HDR_FIRST) ? PH_HUNT_S : PH_HUNT_K;
        endcase
    end

    // field capture and result
    always_comb begin
        length_next    = length_reg;
        pos_next       = pos_reg;
        type_next      = type_reg;
        param_one_next = param_one_reg;
        param_two_next = param_two_reg;
        cr_seen_next   = cr_seen_reg;
        result         = '0;
        result.kind    = KIND_PAYLOAD;
        case (phase_reg)
            PH_LEN: begin
                length_next = {2'b00, rx_byte};
            end
            PH_TYPE: begin
                length_next = len_full;
                type_next   = rx_byte[TYPE_W-1:0];
                if (len_full < MIN_LENGTH) begin
                    result.valid        = 1'b1;
                    result.kind         = KIND_REJECT;
                    result.total_length = len_full;
                end
            end
            PH_P1: begin
                param_one_next = rx_byte;
            end
            PH_P2: begin
                param_two_next = rx_byte;
                pos_next       = BODY_START;
                cr_seen_next   = 1'b0;
            end
            PH_BODY: begin
                if (is_last) begin
                    pos_next            = '0;
                    result.valid        = 1'b1;
                    result.total_length = length_reg;
                    if (cr_seen_reg && (rx_byte == TRL_LF)) begin
                        result.kind         = KIND_ACCEPT;
                        result.packet_kind  = type_reg;
                        result.first_param  = param_one_reg;
                        result.second_param = param_two_reg;
                    end else begin
                        result.kind = KIND_REJECT;
                    end
                end else if (is_cr_slot) begin
                    cr_seen_next = (rx_byte == TRL_CR);
                    pos_next     = pos_plus1[LEN_W-1:0];
                end else begin
                    result.valid         = 1'b1;
                    result.kind          = KIND_PAYLOAD;
                    result.payload_byte  = rx_byte;
                    result.payload_index = pos_reg - BODY_START;
                    pos_next             = pos_plus1[LEN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT_K;
            length_reg    <= '0;
            pos_reg       <= '0;
            type_reg      <= '0;
            param_one_reg <= '0;
            param_two_reg <= '0;
            cr_seen_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            param_one_reg <= param_one_next;
            param_two_reg <= param_two_next;
            cr_seen_reg   <= cr_seen_next;
        end
    end

endmodule
